/* hdl/hsfl_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hsfl_pkg
// shared types, constants and the log table of the scaled forward block
// ----------------------------------------------------------------------------
package hsfl_pkg;

  localparam int NUM_STATES = 4;
  localparam int SW = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
  // matrix entry index
  localparam int MIW = $clog2(NUM_STATES * NUM_STATES);
  localparam int PW = 24;
  localparam int ACCW = 40;
  // raw alpha: sum of NUM_STATES products of Q1.23, rounded to Q.23
  localparam int RAWW = 25 + SW;
  // scale: sum of NUM_STATES raw alphas
  localparam int SCW = RAWW + SW;
  localparam int POSW = $clog2(SCW);
  localparam int DIVW = RAWW + 23;
  localparam int DCW = $clog2(DIVW + 1);
  localparam int LN2_Q16 = 45426;

  typedef enum logic [1:0] {
    REQ_LOAD_M0   = 2'd0,
    REQ_LOAD_M1   = 2'd1,
    REQ_LOAD_INIT = 2'd2,
    REQ_OBS       = 2'd3
  } req_t;

  // controller to datapath
  typedef struct packed {
    logic           clr_acc;     // clear the raw accumulator
    logic           mac;         // one multiply-accumulate step
    logic           raw_done;    // round and store the raw alpha of dst
    logic           div_start;   // load the divider for dst
    logic           div_step;    // one restoring step
    logic           div_done;    // write the quotient to the alpha
    logic           zero_alpha;  // clear alpha of dst
    logic           ln_norm;     // register normalized fraction
    logic           ln_mul;      // interpolation product
    logic           ln_add;      // accumulate ln
    logic           set_zero;    // zero scale seen
    logic           emit;        // load the output register and clear
    logic           use_init;
    logic           obs_bit;
    logic [SW-1:0]  src;
    logic [SW-1:0]  dst;
  } cmd_t;

  typedef struct packed {
    logic scale_zero;
  } sts_t;

  function automatic logic [16:0] ln_tab(input logic [4:0] i);
    logic [16:0] v;
    case (i)
      5'd0:    v = 17'd0;
      5'd1:    v = 17'd3973;
      5'd2:    v = 17'd7719;
      5'd3:    v = 17'd11262;
      5'd4:    v = 17'd14624;
      5'd5:    v = 17'd17821;
      5'd6:    v = 17'd20870;
      5'd7:    v = 17'd23783;
      5'd8:    v = 17'd26573;
      5'd9:    v = 17'd29248;
      5'd10:   v = 17'd31818;
      5'd11:   v = 17'd34292;
      5'd12:   v = 17'd36675;
      5'd13:   v = 17'd38975;
      5'd14:   v = 17'd41196;
      5'd15:   v = 17'd43345;
      5'd16:   v = 17'd45426;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* hdl/hsfl_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hsfl_in_if / hsfl_out_if
// valid/ready channels of the scaled forward block
// ----------------------------------------------------------------------------
interface hsfl_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [1:0]  row_index;
  logic [1:0]  col_index;
  logic [23:0] coef_value;
  logic        obs_bit;
  logic        seq_start;
  logic        job_end;
  modport source (output valid, req_type, row_index, col_index, coef_value,
                  obs_bit, seq_start, job_end, input ready);
  modport sink (input valid, req_type, row_index, col_index, coef_value,
                obs_bit, seq_start, job_end, output ready);
endinterface

interface hsfl_out_if;
  logic               valid;
  logic               ready;
  logic signed [39:0] ll_total;
  logic               zero_sum_seen;
  modport source (output valid, ll_total, zero_sum_seen, input ready);
  modport sink (input valid, ll_total, zero_sum_seen, output ready);
endinterface
`default_nettype wire

/* hdl/hmm_scaled_forward_loglik_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hmm_scaled_forward_loglik_top
// scaled forward recursion with log-likelihood output
// ----------------------------------------------------------------------------
// A load is written at its accepting edge and does not hold off the input. An
// observation runs the multiply-accumulate sweep on one shared multiplier (N
// products and one rounding step per destination), the scale check and log,
// and the restoring divider (DIVW=50) that normalizes each alpha one quotient
// bit per cycle; a zero scale skips log and divider and clears every alpha.
// The input is held off until the observation is done, the divider dominating. On the last
// observation of a job the total is then handed to the output register,
// later while that register still holds an unread result. One
// observation is worked at a time; a finished result sits in the output
// register while the next item enters.
module hmm_scaled_forward_loglik_top (
  input  wire logic clk,
  input  wire logic rst_n,
  hsfl_in_if.sink   in_ch,
  hsfl_out_if.source out_ch
);
  import hsfl_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic busy;
  logic signed [39:0] res_ll;
  logic res_zero;
  logic out_valid_r;
  logic signed [39:0] out_ll_r;
  logic out_zero_r;
  logic acc_w, obs_go;

  assign in_ch.ready = !busy;
  assign acc_w = in_ch.valid && in_ch.ready;
  assign obs_go = acc_w && (in_ch.req_type == REQ_OBS);

  hsfl_ctrl u_ctrl (
    .clk, .rst_n, .obs_go,
    .obs_bit(in_ch.obs_bit), .seq_start(in_ch.seq_start),
    .job_end(in_ch.job_end), .sts,
    .out_free(!out_valid_r || out_ch.ready),
    .cmd, .busy
  );

  hsfl_dp u_dp (
    .clk, .rst_n,
    .ld_en(acc_w && in_ch.req_type != REQ_OBS),
    .ld_type(in_ch.req_type), .ld_row(in_ch.row_index),
    .ld_col(in_ch.col_index), .ld_val(in_ch.coef_value),
    .cmd, .sts, .res_ll, .res_zero
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.emit) out_valid_r <= 1'b1;
    else if (out_ch.ready) out_valid_r <= 1'b0;
    if (cmd.emit) begin
      out_ll_r <= res_ll;
      out_zero_r <= res_zero;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.ll_total = out_ll_r;
  assign out_ch.zero_sum_seen = out_zero_r;

endmodule
`default_nettype wire

/* hdl/hsfl_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hsfl_ctrl
// sequencer of one observation: mac sweep, scale, log, divides
// ----------------------------------------------------------------------------
module hsfl_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          obs_go,
  input  wire logic          obs_bit,
  input  wire logic          seq_start,
  input  wire logic          job_end,
  input  wire hsfl_pkg::sts_t sts,
  input  wire logic          out_free,
  output hsfl_pkg::cmd_t     cmd,
  output logic               busy
);
  import hsfl_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MAC, S_RAW, S_CHK, S_LN0, S_LN1, S_LN2, S_DLOAD, S_DSTEP,
    S_DDONE, S_ZERO, S_EMIT
  } state_t;

  state_t         state_r;
  logic [SW-1:0]  src_r, dst_r;
  logic [DCW-1:0] cnt_r;
  logic           bit_r, init_r, end_r;

  localparam logic [SW-1:0] LAST = SW'(NUM_STATES - 1);

  // command decode
  always_comb begin
    cmd = '0;
    cmd.src = src_r;
    cmd.dst = dst_r;
    cmd.obs_bit = bit_r;
    cmd.use_init = init_r;
    case (state_r)
      S_MAC:   cmd.mac = 1'b1;
      S_RAW:   cmd.raw_done = 1'b1;
      S_CHK:   cmd.set_zero = sts.scale_zero;
      S_LN0:   cmd.ln_norm = 1'b1;
      S_LN1:   cmd.ln_mul = 1'b1;
      S_LN2:   cmd.ln_add = 1'b1;
      S_DLOAD: cmd.div_start = 1'b1;
      S_DSTEP: cmd.div_step = 1'b1;
      S_DDONE: cmd.div_done = 1'b1;
      S_ZERO:  cmd.zero_alpha = 1'b1;
      S_EMIT:  cmd.emit = out_free;
      default: ;
    endcase
    cmd.clr_acc = (state_r == S_IDLE) || (state_r == S_RAW);
  end

  assign busy = (state_r != S_IDLE);

  // state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      src_r <= '0;
      dst_r <= '0;
      cnt_r <= '0;
      bit_r <= 1'b0;
      init_r <= 1'b0;
      end_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: if (obs_go) begin
          bit_r <= obs_bit;
          init_r <= seq_start;
          end_r <= job_end;
          src_r <= '0;
          dst_r <= '0;
          state_r <= S_MAC;
        end
        S_MAC: begin
          if (src_r == LAST) begin
            src_r <= '0;
            state_r <= S_RAW;
          end else src_r <= src_r + 1'b1;
        end
        S_RAW: begin
          if (dst_r == LAST) begin
            dst_r <= '0;
            state_r <= S_CHK;
          end else begin
            dst_r <= dst_r + 1'b1;
            state_r <= S_MAC;
          end
        end
        S_CHK:   state_r <= sts.scale_zero ? S_ZERO : S_LN0;
        S_LN0:   state_r <= S_LN1;
        S_LN1:   state_r <= S_LN2;
        S_LN2:   state_r <= S_DLOAD;
        S_DLOAD: begin
          cnt_r <= DCW'(DIVW - 1);
          state_r <= S_DSTEP;
        end
        S_DSTEP: begin
          if (cnt_r == '0) state_r <= S_DDONE;
          else cnt_r <= cnt_r - 1'b1;
        end
        S_DDONE: begin
          if (dst_r == LAST) begin
            dst_r <= '0;
            state_r <= end_r ? S_EMIT : S_IDLE;
          end else begin
            dst_r <= dst_r + 1'b1;
            state_r <= S_DLOAD;
          end
        end
        S_ZERO: begin
          if (dst_r == LAST) begin
            dst_r <= '0;
            state_r <= end_r ? S_EMIT : S_IDLE;
          end else dst_r <= dst_r + 1'b1;
        end
        S_EMIT:  if (out_free) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
    obs_go |-> state_r == S_IDLE) else $error("observation taken while busy");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> out_free) else $error("emit into full output");
  a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DLOAD) |=> (state_r == S_DSTEP && cnt_r == DCW'(DIVW - 1)))
    else $error("divider count not loaded");

endmodule
`default_nettype wire

/* hdl/hsfl_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hsfl_dp
// storage, shared multiply-accumulate, log unit and restoring divider
// ----------------------------------------------------------------------------
module hsfl_dp (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 ld_en,
  input  wire logic [1:0]           ld_type,
  input  wire logic [1:0]           ld_row,
  input  wire logic [1:0]           ld_col,
  input  wire logic [23:0]          ld_val,
  input  wire hsfl_pkg::cmd_t       cmd,
  output hsfl_pkg::sts_t            sts,
  output logic signed [39:0]        res_ll,
  output logic                      res_zero
);
  import hsfl_pkg::*;

  logic [PW-1:0] m0_r [NUM_STATES*NUM_STATES];
  logic [PW-1:0] m1_r [NUM_STATES*NUM_STATES];
  logic [PW-1:0] init_r [NUM_STATES];
  logic [PW-1:0] alpha_r [NUM_STATES];
  logic [RAWW-1:0] raw_r [NUM_STATES];
  logic [RAWW+23-1:0] acc_r;
  logic [SCW-1:0] scale_r;
  logic signed [ACCW-1:0] ll_r;
  logic zflag_r;

  // row-major matrix entry index
  function automatic logic [MIW-1:0] mat_idx(input logic [SW-1:0] r,
                                             input logic [SW-1:0] c);
    return MIW'(r) * MIW'(NUM_STATES) + MIW'(c);
  endfunction

  // loads: indexes at or beyond NUM_STATES are dropped
  logic [3:0] ld_row_w, ld_col_w;
  logic       ld_ok;
  assign ld_row_w = {2'b00, ld_row};
  assign ld_col_w = {2'b00, ld_col};
  assign ld_ok = (32'(ld_row_w) < NUM_STATES) &&
                 ((ld_type == REQ_LOAD_INIT) || (32'(ld_col_w) < NUM_STATES));

  always_ff @(posedge clk) begin
    if (ld_en && ld_ok) begin
      case (ld_type)
        REQ_LOAD_M0:   m0_r[mat_idx(SW'(ld_row), SW'(ld_col))] <= ld_val;
        REQ_LOAD_M1:   m1_r[mat_idx(SW'(ld_row), SW'(ld_col))] <= ld_val;
        REQ_LOAD_INIT: init_r[SW'(ld_row)] <= ld_val;
        default: ;
      endcase
    end
  end

  // multiply-accumulate over the source states
  logic [PW-1:0] prior_w, coef_w;
  logic [2*PW-1:0] prod_w;
  assign prior_w = cmd.use_init ? init_r[cmd.src] : alpha_r[cmd.src];
  assign coef_w = cmd.obs_bit ? m1_r[mat_idx(cmd.src, cmd.dst)]
                              : m0_r[mat_idx(cmd.src, cmd.dst)];
  assign prod_w = prior_w * coef_w;

  logic [RAWW-1:0] round_w;
  assign round_w = RAWW'((acc_r + (RAWW+23)'(1 << 22)) >> 23);

  always_ff @(posedge clk) begin
    if (cmd.clr_acc) acc_r <= '0;
    else if (cmd.mac) acc_r <= acc_r + (RAWW+23)'(prod_w);
    if (cmd.mac && cmd.src == '0 && cmd.dst == '0) scale_r <= '0;
    if (cmd.raw_done) begin
      raw_r[cmd.dst] <= round_w;
      scale_r <= ((cmd.dst == '0) ? '0 : scale_r) + SCW'(round_w);
    end
  end

  assign sts.scale_zero = (scale_r == '0);

  // log: msb position search, then table interpolation
  logic [POSW-1:0] p_w;
  always_comb begin
    p_w = '0;
    for (int k = 0; k < SCW; k++) if (scale_r[k]) p_w = POSW'(k);
  end

  logic [SCW+15:0] sh_w;
  assign sh_w = {scale_r, 16'd0} >> p_w;

  logic [POSW-1:0] p_r;
  logic [3:0] fi_r;
  logic [11:0] fr_r;
  logic [16:0] t0_r;
  always_ff @(posedge clk) begin
    if (cmd.ln_norm) begin
      p_r <= p_w;
      fi_r <= sh_w[15:12];
      fr_r <= sh_w[11:0];
    end
    if (cmd.ln_mul) t0_r <= ln_tab({1'b0, fi_r});
  end
  // slope between table points times the fraction remainder
  logic [16:0] dtc_w;
  logic [28:0] ipc_w;
  assign dtc_w = ln_tab({1'b0, fi_r} + 5'd1) - ln_tab({1'b0, fi_r});
  assign ipc_w = dtc_w * fr_r;
  logic [28:0] ip2_r;
  always_ff @(posedge clk) if (cmd.ln_mul) ip2_r <= ipc_w;

  logic signed [ACCW+1:0] ln_w, sum_w;
  assign ln_w = (ACCW+2)'($signed({1'b0, p_r}) - 23) * (ACCW+2)'(LN2_Q16)
              + (ACCW+2)'(t0_r) + (ACCW+2)'(ip2_r >> 12);
  assign sum_w = (ACCW+2)'(ll_r) + ln_w;

  // restoring divider: (raw << 23) / scale
  logic [DIVW-1:0] q_r;
  logic [SCW:0] rem_r;
  logic [SCW:0] trial_w;
  assign trial_w = {rem_r[SCW-1:0], q_r[DIVW-1]};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      q_r <= {raw_r[cmd.dst], 23'd0};
      rem_r <= '0;
    end else if (cmd.div_step) begin
      if (trial_w >= {1'b0, scale_r}) begin
        rem_r <= trial_w - {1'b0, scale_r};
        q_r <= {q_r[DIVW-2:0], 1'b1};
      end else begin
        rem_r <= trial_w;
        q_r <= {q_r[DIVW-2:0], 1'b0};
      end
    end
  end

  // alphas, accumulator and flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_STATES; k++) alpha_r[k] <= '0;
      ll_r <= '0;
      zflag_r <= 1'b0;
    end else begin
      if (cmd.div_done) alpha_r[cmd.dst] <= q_r[PW-1:0];
      if (cmd.zero_alpha) alpha_r[cmd.dst] <= '0;
      if (cmd.set_zero) zflag_r <= 1'b1;
      if (cmd.ln_add) begin
        if (sum_w > (ACCW+2)'(41'sd549755813887)) ll_r <= {1'b0, {(ACCW-1){1'b1}}};
        else if (sum_w < -(ACCW+2)'(41'sd549755813888)) ll_r <= {1'b1, {(ACCW-1){1'b0}}};
        else ll_r <= ACCW'(sum_w);
      end
      if (cmd.emit) begin
        ll_r <= '0;
        zflag_r <= 1'b0;
      end
    end
  end

  assign res_ll = ll_r;
  assign res_zero = zflag_r;

  a_zero_no_ln: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.set_zero |-> !cmd.ln_add) else $error("log added on zero scale");
  a_div_scale: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> scale_r != '0) else $error("divide by zero scale");
  a_emit_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (ll_r == '0 && !zflag_r)) else $error("accumulator not cleared");

endmodule
`default_nettype wire

/* sim/hsfl_tb_pkg.sv */
// ----------------------------------------------------------------------------
// hsfl_tb_pkg
// Transaction types shared by the stimulus, driver and monitor of the
// scaled forward log-likelihood testbench.
// ----------------------------------------------------------------------------
package hsfl_tb_pkg;
  import hsfl_pkg::*;

  // one input transaction
  typedef struct {
    req_t        kind;
    logic [1:0]  row;
    logic [1:0]  col;
    logic [23:0] coef;
    logic        bit_val;
    logic        start;
    logic        last;
  } hsfl_req_t;

  // one result transaction
  typedef struct {
    logic signed [39:0] loglik;
    logic               zflag;
  } hsfl_res_t;
endpackage

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Checks the scaled forward log-likelihood block. Random loads and
// observation sequences are driven over the input channel with random idle
// bursts on both sides. An internal model predicts each job result and the
// monitor compares every result, field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import hsfl_pkg::*;
  import hsfl_tb_pkg::*;

  localparam int NS = NUM_STATES;

  logic clk;
  logic rst_n;
  hsfl_in_if  in_ch();
  hsfl_out_if out_ch();

  hmm_scaled_forward_loglik_top DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // model state
  logic [23:0] mz [NS][NS];
  logic [23:0] mo [NS][NS];
  logic [23:0] pi_v [NS];
  logic [23:0] alph [NS];
  longint      acc_ll;
  bit          zseen;

  hsfl_req_t pending_q[$];
  hsfl_res_t loglik_q[$];
  int  errors = 0;
  int  n_obs = 0, n_jobs = 0, n_zero = 0, n_res = 0;
  bit  stim_done = 0;
  bit  calm = 0;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // fixed-point natural log in Q.16
  function automatic longint ln_fix(input longint unsigned sc);
    int p;
    longint unsigned f;
    longint i, r, t0, t1;
    p = 63;
    while (p > 0 && sc[p] == 1'b0) p--;
    if (p >= 16) f = (sc >> (p - 16)) & 16'hFFFF;
    else f = (sc << (16 - p)) & 16'hFFFF;
    i = f >> 12;
    r = f & 12'hFFF;
    t0 = ln_tab(5'(i));
    t1 = ln_tab(5'(i + 1));
    return longint'(p - 23) * LN2_Q16 + t0 + (((t1 - t0) * r) >>> 12);
  endfunction

  // update the model with one accepted transaction
  task automatic predict_forward(input hsfl_req_t t);
    longint unsigned raw [NS];
    longint unsigned sc, sm;
    longint sum;
    hsfl_res_t res;
    sc = 0;
    case (t.kind)
      REQ_LOAD_M0: mz[t.row][t.col] = t.coef;
      REQ_LOAD_M1: mo[t.row][t.col] = t.coef;
      REQ_LOAD_INIT: pi_v[t.row] = t.coef;
      default: begin
        n_obs++;
        for (int d = 0; d < NS; d++) begin
          sm = 0;
          for (int s = 0; s < NS; s++)
            sm += longint'(t.start ? pi_v[s] : alph[s]) *
                  longint'(t.bit_val ? mo[s][d] : mz[s][d]);
          raw[d] = (sm + (64'd1 << 22)) >> 23;
          sc += raw[d];
        end
        if (sc == 0) begin
          zseen = 1;
          n_zero++;
          for (int d = 0; d < NS; d++) alph[d] = '0;
        end else begin
          for (int d = 0; d < NS; d++) alph[d] = 24'((raw[d] << 23) / sc);
          sum = acc_ll + ln_fix(sc);
          if (sum > 64'sd549755813887) sum = 64'sd549755813887;
          if (sum < -64'sd549755813888) sum = -64'sd549755813888;
          acc_ll = sum;
        end
        if (t.last) begin
          res.loglik = 40'(acc_ll);
          res.zflag = zseen;
          loglik_q.push_back(res);
          acc_ll = 0;
          zseen = 0;
          n_jobs++;
        end
      end
    endcase
  endtask

  function automatic hsfl_req_t mk_load(req_t k, int r, int c, logic [23:0] v);
    hsfl_req_t t;
    t.kind = k; t.row = 2'(r); t.col = 2'(c); t.coef = v;
    t.bit_val = 1'($urandom_range(0, 1)); t.start = 1'($urandom_range(0, 1));
    t.last = 1'($urandom_range(0, 1));
    return t;
  endfunction

  function automatic hsfl_req_t mk_obs(bit b, bit s, bit e);
    hsfl_req_t t;
    t.kind = REQ_OBS; t.row = 2'($urandom); t.col = 2'($urandom);
    t.coef = 24'($urandom); t.bit_val = b; t.start = s; t.last = e;
    return t;
  endfunction

  function automatic logic [23:0] rnd_prob();
    case ($urandom_range(0, 5))
      0: return 24'h0;
      1: return 24'hFFFFFF;
      2: return 24'($urandom_range(0, 16));
      default: return 24'($urandom);
    endcase
  endfunction

  // fill all stores with fresh values
  task automatic load_all(input int mode);
    for (int r = 0; r < NS; r++) begin
      for (int c = 0; c < NS; c++) begin
        pending_q.push_back(mk_load(REQ_LOAD_M0, r, c,
          mode == 0 ? 24'hFFFFFF : mode == 1 ? 24'h0 : rnd_prob()));
        pending_q.push_back(mk_load(REQ_LOAD_M1, r, c,
          mode == 0 ? 24'h0 : mode == 1 ? 24'hFFFFFF : rnd_prob()));
      end
      pending_q.push_back(mk_load(REQ_LOAD_INIT, r, $urandom_range(0, 3),
        mode == 0 ? 24'h000001 : mode == 1 ? 24'hFFFFFF : rnd_prob()));
    end
  endtask

  // stimulus
  initial begin
    int nseq;
    int cnt;
    // directed: full loads at extremes, then short jobs
    load_all(1);
    pending_q.push_back(mk_obs(1, 1, 0));
    pending_q.push_back(mk_obs(1, 0, 0));
    pending_q.push_back(mk_obs(0, 0, 1));  // all-zero matrix gives zero scale
    pending_q.push_back(mk_obs(1, 1, 1));
    load_all(0);
    pending_q.push_back(mk_obs(0, 1, 0));  // tiny initial, large matrix
    pending_q.push_back(mk_obs(0, 0, 1));
    cnt = pending_q.size();
    // random: mostly well-formed sequences, some reloads
    while (cnt < 1100) begin
      if ($urandom_range(0, 9) == 0) begin
        load_all(2);
        cnt += 2 * NS * NS + NS;
      end else if ($urandom_range(0, 4) == 0) begin
        pending_q.push_back(mk_load(req_t'($urandom_range(0, 2)),
          $urandom_range(0, 3), $urandom_range(0, 3), rnd_prob()));
        cnt++;
      end else begin
        nseq = $urandom_range(1, 8);
        for (int k = 0; k < nseq; k++) begin
          pending_q.push_back(mk_obs(1'($urandom_range(0, 1)),
            k == 0 ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 9) == 0),
            k == nseq - 1 ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 15) == 0)));
          cnt++;
        end
      end
    end
    pending_q.push_back(mk_obs(0, 1, 1));
    stim_done = 1;
  end

  // reset, then wait for drain
  initial begin
    rst_n = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    wait (stim_done && pending_q.size() == 0 && !in_ch.valid);
    wait (loglik_q.size() == 0);
    repeat (400) @(posedge clk);
    $display("covered %0d observations in %0d jobs, %0d zero-scale steps, %0d results",
             n_obs, n_jobs, n_zero, n_res);
    if (errors == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

  // timeout
  initial begin
    #10ms;
    $display("tb_top NOT OK");
    $finish;
  end

  // input driver with random idle bursts
  int in_gap = 0;
  initial begin
    in_ch.valid = 0; in_ch.req_type = REQ_LOAD_M0; in_ch.row_index = 0;
    in_ch.col_index = 0; in_ch.coef_value = 0; in_ch.obs_bit = 0;
    in_ch.seq_start = 0; in_ch.job_end = 0;
  end
  always @(posedge clk) begin
    hsfl_req_t t;
    if (rst_n) begin
      calm <= (pending_q.size() < 80);
      if (in_ch.valid && in_ch.ready) begin
        t.kind = req_t'(in_ch.req_type); t.row = in_ch.row_index;
        t.col = in_ch.col_index; t.coef = in_ch.coef_value;
        t.bit_val = in_ch.obs_bit; t.start = in_ch.seq_start; t.last = in_ch.job_end;
        predict_forward(t);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_ch.valid <= 0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
          in_gap <= $urandom_range(0, 11);
          in_ch.valid <= 0;
        end else if (pending_q.size() > 0) begin
          t = pending_q.pop_front();
          in_ch.valid <= 1; in_ch.req_type <= t.kind; in_ch.row_index <= t.row;
          in_ch.col_index <= t.col; in_ch.coef_value <= t.coef;
          in_ch.obs_bit <= t.bit_val; in_ch.seq_start <= t.start;
          in_ch.job_end <= t.last;
        end else begin
          in_ch.valid <= 0;
        end
      end
    end
  end

  // result monitor with random stall bursts
  int out_gap = 0;
  initial out_ch.ready = 0;
  always @(posedge clk) begin
    hsfl_res_t e;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        n_res++;
        if (loglik_q.size() == 0) begin
          errors++;
          $display("%t unexpected result ll_total=%0d zero=%0b", $realtime,
                   out_ch.ll_total, out_ch.zero_sum_seen);
        end else begin
          e = loglik_q.pop_front();
          if (out_ch.ll_total !== e.loglik) begin
            errors++;
            $display("%t ll_total expected %0d actual %0d", $realtime,
                     e.loglik, out_ch.ll_total);
          end
          if (out_ch.zero_sum_seen !== e.zflag) begin
            errors++;
            $display("%t zero_sum_seen expected %0b actual %0b", $realtime,
                     e.zflag, out_ch.zero_sum_seen);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ch.ready <= 0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_gap <= $urandom_range(0, 11);
        out_ch.ready <= 0;
      end else begin
        out_ch.ready <= 1;
      end
    end
  end
endmodule
